[sv/usc_pkg.sv]
// usc_pkg: shared types, reciprocal constants and lookup for the
// unix-seconds-to-calendar pipeline. No dependencies.
package usc_pkg;

  // Time of day carried alongside the date computation
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } usc_tod_t;

  // Output of the time split: whole days since epoch plus time of day
  typedef struct packed {
    logic [15:0] days;
    usc_tod_t    tod;
  } usc_split_t;

  // Final calendar result
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    usc_tod_t    tod;
  } usc_cal_t;

  // x/15 = (x * RECIP_15) >> 35, exact for 32-bit x
  localparam logic [31:0] RECIP_15    = 32'h8888_8889;
  localparam int unsigned RECIP_15_SH = 35;
  // x/3 = (x * RECIP_3) >> 33, exact for 32-bit x
  localparam logic [31:0] RECIP_3     = 32'hAAAA_AAAB;
  localparam int unsigned RECIP_3_SH  = 33;

  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
  localparam logic [4:0]  HOURS_PER_DAY = 5'd24;

  // Gregorian century correction
  localparam logic [18:0] CENT_BIAS  = 19'd102032;
  localparam logic [18:0] CENT_LEN1  = 19'd146097;
  localparam logic [18:0] CENT_LEN2  = 19'd292194;
  localparam logic [4:0]  CENT_BASE  = 5'd15;
  localparam logic [21:0] JD_EPOCH   = 22'd2442113;

  // Year count: (20*b - 2442) / 7305, reciprocal with shift 40
  localparam logic [4:0]  YR_SCALE     = 5'd20;
  localparam logic [25:0] YR_BIAS      = 26'd2442;
  localparam logic [27:0] RECIP_7305   = 28'd150514939;
  localparam logic [8:0]  DAYS_PER_YR  = 9'd365;

  // Month: d*1000/30601, folded to one constant, shift 36
  localparam logic [31:0] RECIP_30601K = 32'd2245662000;
  localparam logic [4:0]  DAYS_PER_MON = 5'd30;

  // Month fold-back
  localparam logic [4:0]  LAST_MAR_MONTH = 5'd13;
  localparam logic [4:0]  MAR_MONTH_OFS  = 5'd1;
  localparam logic [4:0]  JAN_MONTH_OFS  = 5'd13;
  localparam logic [12:0] YEAR_OFS_MAR   = 13'd4716;
  localparam logic [12:0] YEAR_OFS_JAN   = 13'd4715;

  // floor(e * 601 / 1000)
  function automatic logic [4:0] month_frac(input logic [4:0] e);
    logic [4:0] r;
    unique case (e)
      5'd0:  r = 5'd0;
      5'd1:  r = 5'd0;
      5'd2:  r = 5'd1;
      5'd3:  r = 5'd1;
      5'd4:  r = 5'd2;
      5'd5:  r = 5'd3;
      5'd6:  r = 5'd3;
      5'd7:  r = 5'd4;
      5'd8:  r = 5'd4;
      5'd9:  r = 5'd5;
      5'd10: r = 5'd6;
      5'd11: r = 5'd6;
      5'd12: r = 5'd7;
      5'd13: r = 5'd7;
      5'd14: r = 5'd8;
      5'd15: r = 5'd9;
      5'd16: r = 5'd9;
      5'd17: r = 5'd10;
      5'd18: r = 5'd10;
      5'd19: r = 5'd11;
      5'd20: r = 5'd12;
      5'd21: r = 5'd12;
      5'd22: r = 5'd13;
      5'd23: r = 5'd13;
      5'd24: r = 5'd14;
      5'd25: r = 5'd15;
      5'd26: r = 5'd15;
      5'd27: r = 5'd16;
      5'd28: r = 5'd16;
      5'd29: r = 5'd17;
      5'd30: r = 5'd18;
      5'd31: r = 5'd18;
    endcase
    return r;
  endfunction

endpackage

[sv/usc_in_if.sv]
// usc_in_if: input channel carrying the seconds count.
// Depends on nothing.
interface usc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink   (input valid, input unix_seconds, output ready);
endinterface

[sv/usc_out_if.sv]
// usc_out_if: output channel carrying the calendar fields.
// Depends on nothing.
interface usc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, output ready);
endinterface

[sv/usc_time_split.sv]
// usc_time_split: three-stage split of seconds into days, hour, minute, second.
// Depends on usc_pkg.
module usc_time_split (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         unix_seconds,
  output logic                out_valid,
  input  logic                out_ready,
  output usc_pkg::usc_split_t out_data
);
  import usc_pkg::*;

  // stage 1: total minutes, second
  logic        v1;
  logic [26:0] q1;
  logic [5:0]  sec1;
  // stage 2: total hours, minute
  logic        v2;
  logic [20:0] q2;
  logic [5:0]  sec2, min2;
  // stage 3: days, hour
  logic        v3;
  logic [15:0] days3;
  logic [5:0]  sec3, min3;
  logic [4:0]  hr3;

  logic        en1, en2, en3;

  logic [61:0] prod1;
  logic [26:0] q1_c;
  logic [5:0]  sec_c;
  logic [56:0] prod2;
  logic [20:0] q2_c;
  logic [5:0]  min_c;
  logic [49:0] prod3;
  logic [15:0] days_c;
  logic [4:0]  hr_c;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // t/60 = (t/4)/15
  assign prod1 = unix_seconds[31:2] * RECIP_15;
  assign q1_c  = prod1[61:RECIP_15_SH];
  assign sec_c = unix_seconds[5:0] - 6'(q1_c[5:0] * SECS_PER_MIN);

  assign prod2 = q1[26:2] * RECIP_15;
  assign q2_c  = prod2[55:RECIP_15_SH];
  assign min_c = q1[5:0] - 6'(q2_c[5:0] * MINS_PER_HOUR);

  // h/24 = (h/8)/3
  assign prod3  = q2[20:3] * RECIP_3;
  assign days_c = prod3[48:RECIP_3_SH];
  assign hr_c   = q2[4:0] - 5'(days_c[4:0] * HOURS_PER_DAY);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      q1   <= q1_c;
      sec1 <= sec_c;
    end
    if (en2) begin
      q2   <= q2_c;
      min2 <= min_c;
      sec2 <= sec1;
    end
    if (en3) begin
      days3 <= days_c;
      hr3   <= hr_c;
      min3  <= min2;
      sec3  <= sec2;
    end
  end

  assign out_valid           = v3;
  assign out_data.days       = days3;
  assign out_data.tod.hour   = hr3;
  assign out_data.tod.minute = min3;
  assign out_data.tod.second = sec3;

endmodule

[sv/usc_date_chain.sv]
// usc_date_chain: five-stage day count to year, month, day conversion.
// Depends on usc_pkg.
module usc_date_chain (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  usc_pkg::usc_split_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output usc_pkg::usc_cal_t   out_data
);
  import usc_pkg::*;

  logic        v4, v5, v6, v7, v8;
  logic        en4, en5, en6, en7, en8;
  usc_tod_t    tod4, tod5, tod6, tod7;

  logic [21:0] b4, b5;
  logic [12:0] c5, c6, c7;
  logic [9:0]  d6, d7;
  logic [4:0]  e7;
  usc_cal_t    res8;

  logic [18:0] n4;
  logic [4:0]  a4;
  logic [21:0] b_c;
  logic [25:0] n5;
  logic [53:0] prod5;
  logic [12:0] c_c;
  logic [21:0] d_full;
  logic [41:0] prod7;
  logic [4:0]  e_c;
  logic [9:0]  f_full;
  usc_cal_t    res_c;

  assign en8      = !v8 || out_ready;
  assign en7      = !v7 || en8;
  assign en6      = !v6 || en7;
  assign en5      = !v5 || en6;
  assign en4      = !v4 || en5;
  assign in_ready = en4;

  // century correction: quotient is 0, 1 or 2 over the input range
  assign n4 = {1'b0, in_data.days, 2'b00} + CENT_BIAS;
  always_comb begin
    priority if (n4 >= CENT_LEN2) a4 = CENT_BASE + 5'd2;
    else if (n4 >= CENT_LEN1)     a4 = CENT_BASE + 5'd1;
    else                          a4 = CENT_BASE;
  end
  assign b_c = 22'(in_data.days) + JD_EPOCH + 22'(a4 - (a4 >> 2));

  assign n5    = 26'(b4) * 26'(YR_SCALE) - YR_BIAS;
  assign prod5 = n5 * RECIP_7305;
  assign c_c   = prod5[52:40];

  // day offset in a March-based year, always under 1024
  assign d_full = b5 - 22'(c5) * 22'(DAYS_PER_YR) - 22'(c5[12:2]);

  assign prod7 = d6 * RECIP_30601K;
  assign e_c   = prod7[40:36];

  assign f_full = d7 - 10'(e7) * 10'(DAYS_PER_MON) - 10'(month_frac(e7));

  always_comb begin
    res_c.tod          = tod7;
    res_c.day_of_month = f_full[4:0];
    if (e7 <= LAST_MAR_MONTH) begin
      res_c.year  = 12'(c7 - YEAR_OFS_MAR);
      res_c.month = 4'(e7 - MAR_MONTH_OFS);
    end else begin
      res_c.year  = 12'(c7 - YEAR_OFS_JAN);
      res_c.month = 4'(e7 - JAN_MONTH_OFS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
      if (en8) v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      b4   <= b_c;
      tod4 <= in_data.tod;
    end
    if (en5) begin
      b5   <= b4;
      c5   <= c_c;
      tod5 <= tod4;
    end
    if (en6) begin
      c6   <= c5;
      d6   <= d_full[9:0];
      tod6 <= tod5;
    end
    if (en7) begin
      c7   <= c6;
      d7   <= d6;
      e7   <= e_c;
      tod7 <= tod6;
    end
    if (en8) begin
      res8 <= res_c;
    end
  end

  assign out_valid = v8;
  assign out_data  = res8;

endmodule

[sv/unix_seconds_to_calendar.sv]
// unix_seconds_to_calendar: seconds since 1970-01-01 00:00:00 UTC to Gregorian
// year, month, day and time of day. Uses usc_pkg, usc_in_if, usc_out_if,
// usc_time_split and usc_date_chain.
// Each input transaction is registered through stages 1 to 8 in order before its matching output transaction.
// Throughput: one transaction per cycle; each stage holds while the next is full.
// Reset (rst, synchronous) clears the stage valid bits only.
module unix_seconds_to_calendar (
  input logic       clk,
  input logic       rst,
  usc_in_if.sink    sec_in,
  usc_out_if.source cal_out
);
  import usc_pkg::*;

  // Stages 1-3 peel off second, minute and hour with reciprocal multiplies
  // (one multiplier per stage). Stages 4-8 run the Julian-day chain:
  //   4: century correction (two compares) and shifted day number
  //   5: year count via reciprocal of 7305
  //   6: day offset within a March-based year
  //   7: March-based month via reciprocal of 30601
  //   8: day of month, fold Jan/Feb into the next year; output register
  // Valid bits travel with the data and each stage has a local ready, so
  // bubbles collapse under backpressure and nothing is dropped or repeated.

  logic       split_valid;
  logic       split_ready;
  usc_split_t split_data;
  usc_cal_t   cal_data;

  usc_time_split u_split (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (sec_in.valid),
    .in_ready     (sec_in.ready),
    .unix_seconds (sec_in.unix_seconds),
    .out_valid    (split_valid),
    .out_ready    (split_ready),
    .out_data     (split_data)
  );

  usc_date_chain u_date (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_data   (split_data),
    .out_valid (cal_out.valid),
    .out_ready (cal_out.ready),
    .out_data  (cal_data)
  );

  assign cal_out.year         = cal_data.year;
  assign cal_out.month        = cal_data.month;
  assign cal_out.day_of_month = cal_data.day_of_month;
  assign cal_out.hour         = cal_data.tod.hour;
  assign cal_out.minute       = cal_data.tod.minute;
  assign cal_out.second       = cal_data.tod.second;

endmodule

[tb/sv/unix_seconds_to_calendar_tb.sv]
// unix_seconds_to_calendar_tb: self-checking bench for the seconds-to-calendar pipeline.
// Depends on usc_in_if, usc_out_if and unix_seconds_to_calendar (usc_pkg via the RTL).
`timescale 1ns / 1ps

module unix_seconds_to_calendar_tb;

  // Expected calendar fields, at the output widths
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_fields_t;

  // One pending conversion: the input seconds plus the calendar they map to
  typedef struct {
    logic [31:0] secs;
    cal_fields_t cal;
  } pending_cal_t;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned MAX_EPOCH_DAY = 49710;  // last day a 32-bit count reaches
  localparam int unsigned STALL_LIMIT  = 4000;    // cycles with no transaction at all
  localparam int unsigned DRAIN_CYCLES = 20;      // pipeline is 8 deep
  localparam int unsigned PRINT_CAP    = 100;

  // Julian-day chain constants
  localparam longint unsigned CENT_OFS   = 102032;
  localparam longint unsigned CENT_DAYS  = 146097;
  localparam longint unsigned CENT_BASE  = 15;
  localparam longint unsigned JDN_1970   = 2442113;
  localparam longint unsigned YEAR_OFS   = 2442;
  localparam longint unsigned YEAR_DIV   = 7305;
  localparam longint unsigned MONTH_DIV  = 30601;
  localparam longint unsigned MONTH_FRAC = 601;
  localparam longint unsigned MARCH_BASE = 4716;
  localparam longint unsigned JAN_BASE   = 4715;
  localparam longint unsigned LAST_MARCH_MONTH = 13;

  logic clk;
  logic rst;

  usc_in_if  sec_in_bus();
  usc_out_if cal_out_bus();

  unix_seconds_to_calendar dut (
    .clk     (clk),
    .rst     (rst),
    .sec_in  (sec_in_bus),
    .cal_out (cal_out_bus)
  );

  // Idle rates in percent per cycle, and the receiver hold-off counter
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  int unsigned mismatches;

  pending_cal_t pending_cal[$];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Calendar predictor: split off seconds, minutes and hours, then walk the
  // day count through the Julian-day chain. Months come out March-based
  // (4..15); January and February fold into the next calendar year.
  // ---------------------------------------------------------------------------
  function automatic cal_fields_t calendar_of(input logic [31:0] secs);
    longint unsigned t, cent_fix, jdn, yr_cnt, yr_day, mon, mday;
    cal_fields_t r;
    t        = secs;
    r.second = 6'(t % 60);
    t        = t / 60;
    r.minute = 6'(t % 60);
    t        = t / 60;
    r.hour   = 5'(t % 24);
    t        = t / 24;

    cent_fix = (4 * t + CENT_OFS) / CENT_DAYS + CENT_BASE;
    jdn      = t + JDN_1970 + cent_fix - cent_fix / 4;
    yr_cnt   = (20 * jdn - YEAR_OFS) / YEAR_DIV;
    yr_day   = jdn - 365 * yr_cnt - yr_cnt / 4;
    mon      = yr_day * 1000 / MONTH_DIV;
    mday     = yr_day - mon * 30 - mon * MONTH_FRAC / 1000;

    if (mon <= LAST_MARCH_MONTH) begin
      yr_cnt = yr_cnt - MARCH_BASE;
      mon    = mon - 1;
    end else begin
      yr_cnt = yr_cnt - JAN_BASE;
      mon    = mon - LAST_MARCH_MONTH;
    end
    r.year         = 12'(yr_cnt);
    r.month        = 4'(mon);
    r.day_of_month = 5'(mday);
    return r;
  endfunction

  // Random timestamp: three in ten fully random, the rest pinned near day,
  // year and end-of-February boundaries where the date chain turns over.
  function automatic logic [31:0] random_seconds();
    longint unsigned v;
    int unsigned yr, days;
    bit leap;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom();
      3, 4, 5: begin
        v = longint'($urandom_range(0, MAX_EPOCH_DAY)) * SECS_PER_DAY;
        case ($urandom_range(3))
          0: v = v;
          1: v = v + 1;
          2: v = v + SECS_PER_DAY - 1;
          default: v = v + $urandom_range(0, SECS_PER_DAY - 1);
        endcase
      end
      default: begin
        yr   = $urandom_range(1970, 2105);
        days = 0;
        for (int y = 1970; y < yr; y++) begin
          days += ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 366 : 365;
        end
        leap = (yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0;
        // Jan 1 or Mar 1 of that year
        if ($urandom_range(1)) days += 59 + leap;
        v = longint'(days) * SECS_PER_DAY;
        if (v > 0 && $urandom_range(1)) v = v - 1 - $urandom_range(0, 59);
        else v = v + $urandom_range(0, 59);
      end
    endcase
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF - $urandom_range(0, 1000);
    return 32'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("mismatch: %s", what);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [11:0] got,
                               input logic [11:0] want, input logic [31:0] secs);
    if (got !== want)
      report_mismatch($sformatf("secs=%0d %s got %0d want %0d", secs, name, got, want));
  endtask

  // Monitor: on each rising edge, check an accepted result against the oldest
  // pending conversion, then queue the prediction for an accepted input.
  initial begin
    pending_cal_t want;
    forever begin
      @(posedge clk);
      if (!rst && cal_out_bus.valid && cal_out_bus.ready) begin
        if (pending_cal.size() == 0) begin
          report_mismatch("result transaction with no input pending");
        end else begin
          want = pending_cal.pop_front();
          compare_field("year", cal_out_bus.year, want.cal.year, want.secs);
          compare_field("month", 12'(cal_out_bus.month), 12'(want.cal.month),
                        want.secs);
          compare_field("day", 12'(cal_out_bus.day_of_month),
                        12'(want.cal.day_of_month), want.secs);
          compare_field("hour", 12'(cal_out_bus.hour), 12'(want.cal.hour),
                        want.secs);
          compare_field("min", 12'(cal_out_bus.minute), 12'(want.cal.minute),
                        want.secs);
          compare_field("sec", 12'(cal_out_bus.second), 12'(want.cal.second),
                        want.secs);
        end
      end
      if (!rst && sec_in_bus.valid && sec_in_bus.ready)
        pending_cal.push_back('{secs: sec_in_bus.unix_seconds,
                                cal: calendar_of(sec_in_bus.unix_seconds)});
    end
  end

  // Watchdog: the quiet count is cleared by a transaction on either channel;
  // once it reaches STALL_LIMIT the pipeline is taken as hung.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((sec_in_bus.valid && sec_in_bus.ready) || (cal_out_bus.valid && cal_out_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // Result receiver: drops ready at random per cycle, or for a counted
  // hold-off stretch when a test asks for one.
  initial begin
    cal_out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        cal_out_bus.ready = 1'b0;
      end else begin
        cal_out_bus.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input driver: idle per cycle at the sender rate, then offer one timestamp
  // and hold it until the transaction completes. Valid stays high across
  // back-to-back transactions.
  // ---------------------------------------------------------------------------
  task automatic send_seconds(input logic [31:0] secs);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sec_in_bus.valid = 1'b0;
      @(negedge clk);
    end
    sec_in_bus.valid        = 1'b1;
    sec_in_bus.unix_seconds = secs;
    do @(posedge clk); while (!sec_in_bus.ready);
  endtask

  // Epoch, 32-bit extremes, minute/hour/day rollovers, leap days (including
  // the non-leap century 2100) and year turnovers.
  task automatic test_directed();
    logic [31:0] corner[$];
    send_idle_pct = 30;
    recv_idle_pct = 30;
    corner = '{32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
               32'd86399, 32'd86400,
               32'd68169600,    // 1972-02-29
               32'd68255999,    // 1972-02-29 23:59:59
               32'd946684799,   // 1999-12-31 23:59:59
               32'd946684800,   // 2000-01-01
               32'd951782400,   // 2000-02-29
               32'd951868800,   // 2000-03-01
               32'd4107542399,  // 2100-02-28 23:59:59
               32'd4107542400,  // 2100-03-01
               32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
               32'd4294944000}; // start of the last reachable day
    foreach (corner[i]) send_seconds(corner[i]);
  endtask

  task automatic test_random(input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_seconds(random_seconds());
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so every stage fills and input ready must drop.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_left = 80;
    repeat (40) send_seconds(random_seconds());
  endtask

  initial begin
    rst                     = 1'b1;
    sec_in_bus.valid        = 1'b0;
    sec_in_bus.unix_seconds = '0;
    send_idle_pct           = 0;
    recv_idle_pct           = 0;
    hold_left               = 0;
    mismatches              = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(12, 82, 340);
    test_random(82, 12, 330);
    test_backpressure();
    test_random(0, 0, 330);

    @(negedge clk);
    sec_in_bus.valid = 1'b0;
    recv_idle_pct    = 0;

    // Drain; the watchdog covers a result that never shows up
    while (pending_cal.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
